@@ hdl/hpack_huffman_string_decoder_top_macros.svh @@
// Assertion macros for the HPACK Huffman string decoder.
`ifndef HPACK_HUFFMAN_STRING_DECODER_TOP_MACROS_SVH
`define HPACK_HUFFMAN_STRING_DECODER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define HHD_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define HHD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/hhd_pkg.sv @@
// Types, code tables and lookup functions for the HPACK Huffman decoder.
package hhd_pkg;

    localparam int NSYM     = 257;
    localparam int EOS_SYM  = 256;
    localparam int MAX_LEN  = 30;
    localparam int SYM_W    = 9;
    localparam int PEND_W   = 37;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_CODE = 2'd1;
    localparam logic [1:0] ST_PAD  = 2'd2;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       string_end;
    } code_req_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       symbol_valid;
        logic [1:0] status;
        logic       done_res;
    } sym_res_t;

    // head of the front queue as seen by the back end
    typedef struct packed {
        logic      valid;
        code_req_t req;
    } q_head_t;

    localparam logic [4:0] CODE_LEN [NSYM] = '{
        5'd13,5'd23,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,
        5'd28,5'd24,5'd30,5'd28,5'd28,5'd30,5'd28,5'd28,
        5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd30,5'd28,
        5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,
        5'd6, 5'd10,5'd10,5'd12,5'd13,5'd6, 5'd8, 5'd11,
        5'd10,5'd10,5'd8, 5'd11,5'd8, 5'd6, 5'd6, 5'd6,
        5'd5, 5'd5, 5'd5, 5'd6, 5'd6, 5'd6, 5'd6, 5'd6,
        5'd6, 5'd6, 5'd7, 5'd8, 5'd15,5'd6, 5'd12,5'd10,
        5'd13,5'd6, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
        5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
        5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
        5'd8, 5'd7, 5'd8, 5'd13,5'd19,5'd13,5'd14,5'd6,
        5'd15,5'd5, 5'd6, 5'd5, 5'd6, 5'd5, 5'd6, 5'd6,
        5'd6, 5'd5, 5'd7, 5'd7, 5'd6, 5'd6, 5'd6, 5'd5,
        5'd6, 5'd7, 5'd6, 5'd5, 5'd5, 5'd6, 5'd7, 5'd7,
        5'd7, 5'd7, 5'd7, 5'd15,5'd11,5'd14,5'd13,5'd28,
        5'd20,5'd22,5'd20,5'd20,5'd22,5'd22,5'd22,5'd23,
        5'd22,5'd23,5'd23,5'd23,5'd23,5'd23,5'd24,5'd23,
        5'd24,5'd24,5'd22,5'd23,5'd24,5'd23,5'd23,5'd23,
        5'd23,5'd21,5'd22,5'd23,5'd22,5'd23,5'd23,5'd24,
        5'd22,5'd21,5'd20,5'd22,5'd22,5'd23,5'd23,5'd21,
        5'd23,5'd22,5'd22,5'd24,5'd21,5'd22,5'd23,5'd23,
        5'd21,5'd21,5'd22,5'd21,5'd23,5'd22,5'd23,5'd23,
        5'd20,5'd22,5'd22,5'd22,5'd23,5'd22,5'd22,5'd23,
        5'd26,5'd26,5'd20,5'd19,5'd22,5'd23,5'd22,5'd25,
        5'd26,5'd26,5'd26,5'd27,5'd27,5'd26,5'd24,5'd25,
        5'd19,5'd21,5'd26,5'd27,5'd27,5'd26,5'd27,5'd24,
        5'd21,5'd21,5'd26,5'd26,5'd28,5'd27,5'd27,5'd27,
        5'd20,5'd24,5'd20,5'd21,5'd22,5'd21,5'd21,5'd23,
        5'd22,5'd22,5'd25,5'd25,5'd24,5'd24,5'd26,5'd23,
        5'd26,5'd27,5'd26,5'd26,5'd27,5'd27,5'd27,5'd27,
        5'd27,5'd28,5'd27,5'd27,5'd27,5'd27,5'd27,5'd26,
        5'd30
    };

    // per-length symbol counts, 9 bits per length 0..MAX_LEN
    function automatic logic [(MAX_LEN+1)*SYM_W-1:0] build_count();
        logic [(MAX_LEN+1)*SYM_W-1:0] r;
        int c;
        r = '0;
        for (int l = 1; l <= MAX_LEN; l++)
        begin
            c = 0;
            for (int s = 0; s < NSYM; s++)
                if (int'(CODE_LEN[s]) == l)
                    c++;
            r[l*SYM_W +: SYM_W] = SYM_W'(c);
        end
        return r;
    endfunction

    localparam logic [(MAX_LEN+1)*SYM_W-1:0] COUNT_TAB = build_count();

    function automatic logic [(MAX_LEN+1)*MAX_LEN-1:0] build_first();
        logic [(MAX_LEN+1)*MAX_LEN-1:0] r;
        longint code;
        r = '0;
        code = 0;
        for (int l = 1; l <= MAX_LEN; l++)
        begin
            code = (code + ((l == 1) ? 0 : longint'(COUNT_TAB[(l-1)*SYM_W +: SYM_W]))) << 1;
            r[l*MAX_LEN +: MAX_LEN] = MAX_LEN'(code);
        end
        return r;
    endfunction

    function automatic logic [(MAX_LEN+1)*SYM_W-1:0] build_offset();
        logic [(MAX_LEN+1)*SYM_W-1:0] r;
        int pos;
        r = '0;
        pos = 0;
        for (int l = 1; l <= MAX_LEN; l++)
        begin
            r[l*SYM_W +: SYM_W] = SYM_W'(pos);
            pos = pos + int'(COUNT_TAB[l*SYM_W +: SYM_W]);
        end
        return r;
    endfunction

    // symbols in canonical order: by length, then by value
    function automatic logic [NSYM*SYM_W-1:0] build_sorted();
        logic [NSYM*SYM_W-1:0] r;
        int pos;
        r = '0;
        pos = 0;
        for (int l = 1; l <= MAX_LEN; l++)
            for (int s = 0; s < NSYM; s++)
                if (int'(CODE_LEN[s]) == l)
                begin
                    r[pos*SYM_W +: SYM_W] = SYM_W'(s);
                    pos++;
                end
        return r;
    endfunction

    localparam logic [(MAX_LEN+1)*MAX_LEN-1:0] FIRST_TAB  = build_first();
    localparam logic [(MAX_LEN+1)*SYM_W-1:0]   OFFSET_TAB = build_offset();
    localparam logic [NSYM*SYM_W-1:0]          SORTED_TAB = build_sorted();

    function automatic logic [MAX_LEN-1:0] first_code(logic [4:0] l);
        return FIRST_TAB[int'(l)*MAX_LEN +: MAX_LEN];
    endfunction

    function automatic logic [SYM_W-1:0] len_count(logic [4:0] l);
        return COUNT_TAB[int'(l)*SYM_W +: SYM_W];
    endfunction

    function automatic logic [SYM_W-1:0] len_offset(logic [4:0] l);
        return OFFSET_TAB[int'(l)*SYM_W +: SYM_W];
    endfunction

    function automatic logic [SYM_W-1:0] sorted_sym(logic [SYM_W-1:0] idx);
        return SORTED_TAB[int'(idx)*SYM_W +: SYM_W];
    endfunction

endpackage

@@ hdl/hhd_front.sv @@
// Front end: accepts code bytes into a two-entry queue.
module hhd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               code_valid,
    output logic               code_stall,
    input  hhd_pkg::code_req_t code_req,
    output hhd_pkg::q_head_t   q_head,
    input  logic               q_pop
);

    hhd_pkg::code_req_t slot_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, rd_next;
    logic       wr_reg, wr_next;
    logic       push;
    logic       pop;

    assign code_stall = (cnt_reg == 2'd2);
    assign push = code_valid && !code_stall;
    assign pop  = q_pop && (cnt_reg != 2'd0);

    assign q_head.valid = (cnt_reg != 2'd0);
    assign q_head.req   = slot_reg[rd_reg];

    always_comb
    begin
        rd_next  = pop ? !rd_reg : rd_reg;
        wr_next  = push ? !wr_reg : wr_reg;
        cnt_next = 2'(cnt_reg + {1'b0, push} - {1'b0, pop});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= code_req;
        end
    end

endmodule

@@ hdl/hhd_back.sv @@
// Back end: bit-serial canonical Huffman walk, bit buffer and result sequencing.
module hhd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  hhd_pkg::q_head_t    q_head,
    output logic                q_pop,
    output logic                res_valid,
    input  logic                res_stall,
    output hhd_pkg::sym_res_t   res
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [36:0]       pend_reg, pend_next;
    logic [5:0]        pcnt_reg, pcnt_next;
    logic [29:0]       code_reg, code_next;
    logic [4:0]        len_reg, len_next;
    logic              err_reg, err_next;
    logic              last_reg, last_next;
    logic [7:0]        sym0_reg, sym0_next;
    logic [7:0]        sym1_reg, sym1_next;
    logic [1:0]        nsym_reg, nsym_next;
    logic              close_reg, close_next;
    logic [1:0]        cstat_reg, cstat_next;
    logic [1:0]        e_reg, e_next;
    logic              rv_reg, rv_next;
    hhd_pkg::sym_res_t res_reg, res_next;

    logic [5:0]        pos;
    logic              nbit;
    logic [29:0]       code_w;
    logic [4:0]        len_w;
    logic [29:0]       fc;
    logic [29:0]       diff;
    logic              hit;
    logic [8:0]        idx;
    logic [8:0]        sym_w;
    logic              go_fin;
    logic              fin_bad;
    logic [5:0]        pcnt_fin;
    logic [1:0]        n_fin;
    logic [6:0]        pad_mask;
    logic              pad_ok;
    logic [1:0]        total;
    logic [1:0]        total_fin;
    logic              slot_free;

    assign res_valid = rv_reg;
    assign res       = res_reg;
    assign q_pop     = (state_reg == S_IDLE) && q_head.valid;
    assign slot_free = !rv_reg || !res_stall;
    assign total     = 2'(nsym_reg + {1'b0, close_reg});

    // one code bit per cycle while in S_WALK, match checked against per-length first code
    always_comb
    begin
        pos    = 6'(pcnt_reg - 6'd1 - {1'b0, len_reg});
        nbit   = pend_reg[pos];
        code_w = {code_reg[28:0], nbit};
        len_w  = 5'(len_reg + 5'd1);
        fc     = hhd_pkg::first_code(len_w);
        diff   = 30'(code_w - fc);
        hit    = (code_w >= fc) && (diff < {21'd0, hhd_pkg::len_count(len_w)});
        idx    = 9'(hhd_pkg::len_offset(len_w) + diff[8:0]);
        sym_w  = hhd_pkg::sorted_sym(idx);
    end

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        pcnt_next  = pcnt_reg;
        code_next  = code_reg;
        len_next   = len_reg;
        err_next   = err_reg;
        last_next  = last_reg;
        sym0_next  = sym0_reg;
        sym1_next  = sym1_reg;
        nsym_next  = nsym_reg;
        close_next = close_reg;
        cstat_next = cstat_reg;
        e_next     = e_reg;
        rv_next    = (rv_reg && !res_stall) ? 1'b0 : rv_reg;
        res_next   = res_reg;
        go_fin     = 1'b0;
        fin_bad    = 1'b0;
        pcnt_fin   = pcnt_reg;
        n_fin      = nsym_reg;
        pad_mask   = 7'd0;
        pad_ok     = 1'b0;
        total_fin  = 2'd0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_head.valid)
                begin
                    if (err_reg)
                    begin
                        // string already failed: swallow bytes until its end
                        if (q_head.req.string_end)
                            err_next = 1'b0;
                    end
                    else
                    begin
                        pend_next  = {pend_reg[28:0], q_head.req.code_byte};
                        pcnt_next  = 6'(pcnt_reg + 6'd8);
                        last_next  = q_head.req.string_end;
                        nsym_next  = 2'd0;
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                if ({1'b0, len_reg} == pcnt_reg)
                begin
                    go_fin = 1'b1;
                end
                else if (hit)
                begin
                    if (sym_w == 9'(hhd_pkg::EOS_SYM))
                    begin
                        go_fin  = 1'b1;
                        fin_bad = 1'b1;
                    end
                    else
                    begin
                        if (nsym_reg == 2'd0)
                            sym0_next = sym_w[7:0];
                        else
                            sym1_next = sym_w[7:0];
                        n_fin     = 2'(nsym_reg + 2'd1);
                        nsym_next = n_fin;
                        pcnt_fin  = 6'(pcnt_reg - {1'b0, len_w});
                        pcnt_next = pcnt_fin;
                        code_next = 30'd0;
                        len_next  = 5'd0;
                        go_fin    = (n_fin == 2'd2);
                    end
                end
                else if (len_w == 5'(hhd_pkg::MAX_LEN))
                begin
                    go_fin  = 1'b1;
                    fin_bad = 1'b1;
                end
                else
                begin
                    code_next = code_w;
                    len_next  = len_w;
                end

                if (go_fin)
                begin
                    pad_mask = 7'((8'd1 << pcnt_fin[2:0]) - 8'd1);
                    pad_ok   = (pcnt_fin <= 6'd7) && ((pend_reg[6:0] | ~pad_mask) == 7'h7f);
                    if (fin_bad || last_reg)
                    begin
                        close_next = 1'b1;
                        cstat_next = fin_bad ? hhd_pkg::ST_CODE
                                   : (pad_ok ? hhd_pkg::ST_OK : hhd_pkg::ST_PAD);
                        pend_next  = '0;
                        pcnt_next  = 6'd0;
                        code_next  = 30'd0;
                        len_next   = 5'd0;
                        if (fin_bad)
                            err_next = !last_reg;
                    end
                    else
                    begin
                        close_next = 1'b0;
                    end
                    total_fin  = 2'(n_fin + {1'b0, close_next});
                    e_next     = 2'd0;
                    state_next = (total_fin == 2'd0) ? S_IDLE : S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    rv_next = 1'b1;
                    if (e_reg < nsym_reg)
                    begin
                        res_next.symbol       = e_reg[0] ? sym1_reg : sym0_reg;
                        res_next.symbol_valid = 1'b1;
                        res_next.status       = hhd_pkg::ST_OK;
                        res_next.done_res     = (2'(e_reg + 2'd1) == nsym_reg) && !close_reg;
                    end
                    else
                    begin
                        res_next.symbol       = 8'd0;
                        res_next.symbol_valid = 1'b0;
                        res_next.status       = cstat_reg;
                        res_next.done_res     = 1'b1;
                    end
                    e_next = 2'(e_reg + 2'd1);
                    if (2'(e_reg + 2'd1) == total)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= '0;
            pcnt_reg  <= 6'd0;
            code_reg  <= 30'd0;
            len_reg   <= 5'd0;
            err_reg   <= 1'b0;
            last_reg  <= 1'b0;
            nsym_reg  <= 2'd0;
            close_reg <= 1'b0;
            cstat_reg <= hhd_pkg::ST_OK;
            e_reg     <= 2'd0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            pcnt_reg  <= pcnt_next;
            code_reg  <= code_next;
            len_reg   <= len_next;
            err_reg   <= err_next;
            last_reg  <= last_next;
            nsym_reg  <= nsym_next;
            close_reg <= close_next;
            cstat_reg <= cstat_next;
            e_reg     <= e_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym0_reg <= sym0_next;
        sym1_reg <= sym1_next;
        res_reg  <= res_next;
    end

endmodule

@@ hdl/hpack_huffman_string_decoder_top.sv @@
// Top level of the HPACK Huffman string decoder.
//
//  channel   | valid       | stall       | payload
//  ----------+-------------+-------------+------------------------------
//  code in   | code_valid  | code_stall  | code_req  (code_byte, string_end)
//  result    | res_valid   | res_stall   | res (symbol, symbol_valid, status, done_res)
//
// A byte is loaded into the bit buffer and walked one code bit per cycle, with a closing
// step when the walk runs out of buffered bits, and results go out one per cycle while
// res_stall is low; the bit-serial table walk in the back end sets this.
// A two-entry request queue lets bytes arrive while the back end is busy.
// Reset clears the bit buffer, the error flag, the request queue and the result valid flag.
// A stalled result holds in the output register and pauses the back end only.
`include "hpack_huffman_string_decoder_top_macros.svh"

module hpack_huffman_string_decoder_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               code_valid,
    output logic               code_stall,
    input  hhd_pkg::code_req_t code_req,
    output logic               res_valid,
    input  logic               res_stall,
    output hhd_pkg::sym_res_t  res
);

    hhd_pkg::q_head_t q_head;
    logic             q_pop;

    hhd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .code_req   (code_req),
        .q_head     (q_head),
        .q_pop      (q_pop)
    );

    hhd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

    `HHD_ASSERT_IMPLY(a_err_closes,
        res_valid && (res.status != hhd_pkg::ST_OK),
        res.done_res && !res.symbol_valid,
        "error result must close without a symbol")
    `HHD_ASSERT_IMPLY(a_sym_ok,
        res_valid && res.symbol_valid,
        res.status == hhd_pkg::ST_OK,
        "symbol result with nonzero status")
    `HHD_ASSERT_NEXT(a_burst,
        res_valid && !res_stall && res.symbol_valid && !res.done_res,
        res_valid,
        "result burst broken before its closing result")

endmodule
